// ----- hw/rtl/dlnfk_pkg.sv -----
// Shared constants and types for the double-layer near-field kernel.
`timescale 1ns / 1ps
package dlnfk_pkg;

  // Default number of fraction bits of the fixed-point format.
  localparam int FRAC_BITS_DEF = 16;

  // Stage map of the pipeline.
  localparam int PRE_STAGES = 7;   // difference, products, sums, sign, numerator
  localparam int SQ_STAGES  = 33;  // one root bit per stage, bits 32 down to 0
  localparam int DIV_STAGES = 33;  // overflow test, then quotient bits 31 down to 0
  localparam int SQ0        = PRE_STAGES;
  localparam int CM1        = SQ0 + SQ_STAGES;
  localparam int CM2        = CM1 + 1;
  localparam int DV0        = CM2 + 1;
  localparam int OUT_STG    = DV0 + DIV_STAGES;
  localparam int N_STAGES   = OUT_STG + 1;

  // Fixed datapath widths.
  localparam int NUM_W  = 97;   // |n.d| * |s| before the fraction shift
  localparam int CUBE_W = 99;   // Q * floor(sqrt(Q))
  localparam int CMP_W  = 131;  // divisor shifted by up to 32 places

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_SAT  = 2'd2
  } status_t;

endpackage

// ----- hw/rtl/double_layer_near_field_kernel.sv -----
// Double-layer near-field kernel: s * (n.d) / |d|^3 in fixed point, fully pipelined.
`timescale 1ns / 1ps
// Throughput: one beat per cycle while the output side is ready; the 33-stage root pipeline
// and the 33-stage divider lanes each retire one item per cycle, so any stage can take a new
// item every cycle unless a stall from the output side holds it.
// Each stage holds only while it is full and the stage after it cannot move on, so bubbles close up.
// Reset (rst, synchronous, active high) clears every stage valid bit; data registers are not reset.
module double_layer_near_field_kernel #(
  parameter int FRAC_BITS = dlnfk_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // eval_x, eval_y, eval_z, src_x, src_y, src_z, strength_x, strength_y, strength_z,
  // normal_x, normal_y, normal_z; 32 bits each from bit 0 up
  input  logic [383:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // field_x, field_y, field_z; 32 bits each from bit 0 up
  output logic [95:0]  m_axis_tdata,
  // status
  output logic [1:0]   m_axis_tuser
);
  import dlnfk_pkg::*;

  localparam int NW = NUM_W + FRAC_BITS;

  typedef struct packed {
    logic [2:0][NUM_W-1:0] num;
    logic [2:0]            neg_out;
    logic [2:0]            num_zero;
    logic                  zero_dist;
  } side_t;

  typedef struct packed {
    logic [CUBE_W-1:0]  cube;
    logic [2:0][NW-1:0] rem;
    logic [2:0][31:0]   quo;
    logic [2:0]         ovf;
    logic [2:0]         neg_out;
    logic [2:0]         num_zero;
    logic               zero_dist;
  } div_t;

  // Stage valid bits and per-stage move enables.
  logic [N_STAGES-1:0] v;
  logic [N_STAGES:0]   en;

  always_comb begin
    en[N_STAGES] = m_axis_tready;
    for (int k = N_STAGES - 1; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = v[OUT_STG];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < N_STAGES; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // Stage 1: difference vector and magnitudes.
  logic [31:0] s1_dmag [3];
  logic [31:0] s1_nmag [3];
  logic [31:0] s1_smag [3];
  logic [2:0]  s1_dneg, s1_nneg, s1_sneg;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        logic [31:0] e, sp, st, nm;
        logic [32:0] d;
        e  = s_axis_tdata[32*i +: 32];
        sp = s_axis_tdata[32*(3+i) +: 32];
        st = s_axis_tdata[32*(6+i) +: 32];
        nm = s_axis_tdata[32*(9+i) +: 32];
        d  = {e[31], e} - {sp[31], sp};
        s1_dneg[i] <= d[32];
        s1_dmag[i] <= d[32] ? 32'(~d + 33'd1) : d[31:0];
        s1_nneg[i] <= nm[31];
        s1_nmag[i] <= nm[31] ? (~nm + 32'd1) : nm;
        s1_sneg[i] <= st[31];
        s1_smag[i] <= st[31] ? (~st + 32'd1) : st;
      end
    end
  end

  // Stage 2: squares and normal products.
  logic [63:0] s2_sq [3];
  logic [63:0] s2_nd [3];
  logic [31:0] s2_smag [3];
  logic [2:0]  s2_ndneg, s2_sneg;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        s2_sq[i]    <= s1_dmag[i] * s1_dmag[i];
        s2_nd[i]    <= s1_nmag[i] * s1_dmag[i];
        s2_ndneg[i] <= s1_nneg[i] ^ s1_dneg[i];
        s2_smag[i]  <= s1_smag[i];
        s2_sneg[i]  <= s1_sneg[i];
      end
    end
  end

  // Stage 3: squared distance and the two signed halves of n.d.
  logic [65:0] s3_q, s3_pos, s3_neg;
  logic [31:0] s3_smag [3];
  logic [2:0]  s3_sneg;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      logic [65:0] p, n;
      p = '0;
      n = '0;
      for (int i = 0; i < 3; i++) begin
        if (s2_ndneg[i]) begin
          n = n + {2'b00, s2_nd[i]};
        end else begin
          p = p + {2'b00, s2_nd[i]};
        end
      end
      s3_q    <= {2'b00, s2_sq[0]} + {2'b00, s2_sq[1]} + {2'b00, s2_sq[2]};
      s3_pos  <= p;
      s3_neg  <= n;
      s3_smag <= s2_smag;
      s3_sneg <= s2_sneg;
    end
  end

  // Stage 4: signed n.d.
  logic [65:0] s4_q;
  logic [66:0] s4_diff;
  logic [31:0] s4_smag [3];
  logic [2:0]  s4_sneg;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_q    <= s3_q;
      s4_diff <= {1'b0, s3_pos} - {1'b0, s3_neg};
      s4_smag <= s3_smag;
      s4_sneg <= s3_sneg;
    end
  end

  // Stage 5: magnitude and sign of n.d.
  logic [65:0] s5_q;
  logic [64:0] s5_pmag;
  logic        s5_pneg;
  logic [31:0] s5_smag [3];
  logic [2:0]  s5_sneg;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_q    <= s4_q;
      s5_pneg <= s4_diff[66];
      s5_pmag <= s4_diff[66] ? 65'(~s4_diff + 67'd1) : s4_diff[64:0];
      s5_smag <= s4_smag;
      s5_sneg <= s4_sneg;
    end
  end

  // Stage 6: numerator partial products, split to keep each multiplier at 33 by 32.
  logic [65:0] s6_q;
  logic [64:0] s6_pplo [3];
  logic [63:0] s6_pphi [3];
  logic        s6_pneg;
  logic [2:0]  s6_sneg, s6_nzero;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int i = 0; i < 3; i++) begin
        s6_pplo[i]  <= s5_pmag[32:0] * s5_smag[i];
        s6_pphi[i]  <= s5_pmag[64:33] * s5_smag[i];
        s6_nzero[i] <= (s5_pmag == '0) || (s5_smag[i] == '0);
      end
      s6_q    <= s5_q;
      s6_pneg <= s5_pneg;
      s6_sneg <= s5_sneg;
    end
  end

  // Stage 7: full numerators and result signs.
  logic [65:0] s7_q;
  side_t       s7_side;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int i = 0; i < 3; i++) begin
        s7_side.num[i]      <= {32'd0, s6_pplo[i]} + {s6_pphi[i], 33'd0};
        s7_side.neg_out[i]  <= s6_pneg ^ s6_sneg[i];
        s7_side.num_zero[i] <= s6_nzero[i];
      end
      s7_side.zero_dist <= (s6_q == '0);
      s7_q              <= s6_q;
    end
  end

  // Square root: one result bit per stage, remainder kept as Q - root^2.
  logic [66:0] sq_rem  [SQ_STAGES];
  logic [32:0] sq_root [SQ_STAGES];
  logic [65:0] sq_q    [SQ_STAGES];
  side_t       sq_side [SQ_STAGES];

  for (genvar j = 0; j < SQ_STAGES; j++) begin : g_sqrt
    localparam int B = SQ_STAGES - 1 - j;
    logic [66:0] rem_in;
    logic [32:0] root_in;
    logic [65:0] q_in;
    side_t       side_in;
    logic [67:0] trial;
    logic        fit;

    if (j == 0) begin : g_first
      assign rem_in  = {1'b0, s7_q};
      assign root_in = '0;
      assign q_in    = s7_q;
      assign side_in = s7_side;
    end else begin : g_next
      assign rem_in  = sq_rem[j-1];
      assign root_in = sq_root[j-1];
      assign q_in    = sq_q[j-1];
      assign side_in = sq_side[j-1];
    end

    always_comb begin
      trial = ({35'd0, root_in} << (B + 1)) + (68'd1 << (2 * B));
      fit   = trial <= {1'b0, rem_in};
    end

    always_ff @(posedge clk) begin
      if (en[SQ0+j]) begin
        sq_rem[j]  <= fit ? (rem_in - trial[66:0]) : rem_in;
        sq_root[j] <= fit ? (root_in | (33'd1 << B)) : root_in;
        sq_q[j]    <= q_in;
        sq_side[j] <= side_in;
      end
    end
  end

  // Distance cube, first stage: two 33 by 33 partial products.
  logic [65:0] cm1_lo, cm1_hi;
  side_t       cm1_side;

  always_ff @(posedge clk) begin
    if (en[CM1]) begin
      cm1_lo   <= sq_q[SQ_STAGES-1][32:0] * sq_root[SQ_STAGES-1];
      cm1_hi   <= sq_q[SQ_STAGES-1][65:33] * sq_root[SQ_STAGES-1];
      cm1_side <= sq_side[SQ_STAGES-1];
    end
  end

  // Distance cube, second stage: combine the partial products.
  logic [CUBE_W-1:0] cm2_cube;
  side_t             cm2_side;

  always_ff @(posedge clk) begin
    if (en[CM2]) begin
      cm2_cube <= {33'd0, cm1_lo} + {cm1_hi, 33'd0};
      cm2_side <= cm1_side;
    end
  end

  // Divider lanes: an overflow test against 2^32, then restoring steps for 32 quotient bits.
  div_t dv [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (en[DV0]) begin
      for (int i = 0; i < 3; i++) begin
        logic [NW-1:0] sh;
        sh = {cm2_side.num[i], {FRAC_BITS{1'b0}}};
        dv[0].rem[i] <= sh;
        dv[0].quo[i] <= '0;
        dv[0].ovf[i] <= {{(CMP_W-NW){1'b0}}, sh} >= {cm2_cube, 32'd0};
      end
      dv[0].cube      <= cm2_cube;
      dv[0].neg_out   <= cm2_side.neg_out;
      dv[0].num_zero  <= cm2_side.num_zero;
      dv[0].zero_dist <= cm2_side.zero_dist;
    end
  end

  for (genvar k = 1; k < DIV_STAGES; k++) begin : g_div
    localparam int B = DIV_STAGES - 1 - k;
    logic [CMP_W-1:0] dvs;
    logic [CMP_W-1:0] remx [3];
    logic [2:0]       fit;
    div_t             nxt;

    // One restoring step per lane.
    always_comb begin
      dvs = {32'd0, dv[k-1].cube} << B;
      nxt = dv[k-1];
      for (int i = 0; i < 3; i++) begin
        remx[i] = {{(CMP_W-NW){1'b0}}, dv[k-1].rem[i]};
        fit[i]  = remx[i] >= dvs;
        if (fit[i]) begin
          nxt.rem[i]    = NW'(remx[i] - dvs);
          nxt.quo[i][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[DV0+k]) begin
        dv[k] <= nxt;
      end
    end
  end

  // Output stage: saturation, sign and status.
  logic [31:0] o_field [3];
  status_t     o_status;

  always_ff @(posedge clk) begin
    if (en[OUT_STG]) begin
      logic [2:0]  sat;
      logic [31:0] limit, m;
      for (int i = 0; i < 3; i++) begin
        limit  = dv[DIV_STAGES-1].neg_out[i] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        sat[i] = !dv[DIV_STAGES-1].num_zero[i] &&
                 (dv[DIV_STAGES-1].ovf[i] || (dv[DIV_STAGES-1].quo[i] > limit));
        m      = sat[i] ? limit : dv[DIV_STAGES-1].quo[i];
        if (dv[DIV_STAGES-1].zero_dist || dv[DIV_STAGES-1].num_zero[i]) begin
          o_field[i] <= '0;
        end else begin
          o_field[i] <= dv[DIV_STAGES-1].neg_out[i] ? (~m + 32'd1) : m;
        end
      end
      if (dv[DIV_STAGES-1].zero_dist) begin
        o_status <= ST_ZERO;
      end else if (sat != '0) begin
        o_status <= ST_SAT;
      end else begin
        o_status <= ST_OK;
      end
    end
  end

  assign m_axis_tdata = {o_field[2], o_field[1], o_field[0]};
  assign m_axis_tuser = o_status;

endmodule

// ----- hw/rtl/dlnfk_checker.sv -----
// Port-level checks for the double-layer near-field kernel, bound to the top level.
`timescale 1ns / 1ps
module dlnfk_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [383:0] s_axis_tdata,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [95:0]  m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);
  import dlnfk_pkg::*;

  // A zero-distance result carries all-zero field components.
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == ST_ZERO)) |-> (m_axis_tdata == '0))
    else $error("zero-distance beat with non-zero fields");

  // With the output side ready, every stage moves, so the input side is ready too.
  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output is ready");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result beat straight after reset");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result beat changed");

endmodule

bind double_layer_near_field_kernel dlnfk_checker u_dlnfk_checker (.*);

// ----- tb/double_layer_near_field_kernel_checker.sv -----
// Checker for the double-layer kernel: predicts every result beat and compares it.
`timescale 1ns / 1ps
module double_layer_near_field_kernel_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [383:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [95:0]  m_axis_tdata,
  input  logic [1:0]   m_axis_tuser,
  output int           mismatch_count,
  output int           fields_pending
);
  import dlnfk_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;

  typedef struct packed {
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic signed [31:0] fz;
    status_t            st;
  } field_t;

  field_t field_queue[$];

  // Kernel model: s * (n.d) / (|d|^2 * floor(|d|)), truncated toward zero and saturated.
  function automatic field_t kernel_field(input logic [383:0] beat);
    logic signed [127:0] dv, nv, sv, dist_sq, dot;
    logic [127:0] root, cand, cube, pmag, smag, num, quo, limit;
    logic pneg, neg_out, sat;
    logic [31:0] comp [3];
    field_t f;
    dist_sq = 0;
    dot = 0;
    for (int i = 0; i < 3; i++) begin
      dv = $signed(beat[32*i +: 32]) - $signed(beat[32*(i+3) +: 32]);
      nv = $signed(beat[32*(i+9) +: 32]);
      dist_sq += dv * dv;
      dot += nv * dv;
    end
    if (dist_sq == 0) begin
      f.fx = '0;
      f.fy = '0;
      f.fz = '0;
      f.st = ST_ZERO;
      return f;
    end
    // Integer square root, one bit at a time.
    root = 0;
    for (int b = 40; b >= 0; b--) begin
      cand = root | (128'd1 << b);
      if (cand * cand <= dist_sq) root = cand;
    end
    cube = dist_sq * root;
    pneg = dot < 0;
    pmag = pneg ? -dot : dot;
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      sv = $signed(beat[32*(i+6) +: 32]);
      smag = (sv < 0) ? -sv : sv;
      num = pmag * smag;
      if (num == 0) begin
        comp[i] = '0;
      end else begin
        neg_out = pneg ^ (sv < 0);
        quo = (num << FRAC) / cube;
        limit = neg_out ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (quo > limit) begin
          quo = limit;
          sat = 1'b1;
        end
        comp[i] = neg_out ? 32'(-quo) : quo[31:0];
      end
    end
    f.fx = comp[0];
    f.fy = comp[1];
    f.fz = comp[2];
    f.st = sat ? ST_SAT : ST_OK;
    return f;
  endfunction

  assign fields_pending = field_queue.size();

  // Predict on each input beat, compare on each result beat.
  always @(posedge clk) begin
    field_t want, got;
    if (rst) begin
      mismatch_count <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) field_queue.push_back(kernel_field(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got.fx = m_axis_tdata[31:0];
        got.fy = m_axis_tdata[63:32];
        got.fz = m_axis_tdata[95:64];
        got.st = status_t'(m_axis_tuser);
        if (field_queue.size() == 0) begin
          if (mismatch_count < 10) $display("Result beat with no prediction: %h %h",
                                            m_axis_tdata, m_axis_tuser);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = field_queue.pop_front();
          if (got !== want) begin
            if (mismatch_count < 10)
              $display("Mismatch: expected x=%h y=%h z=%h st=%0d, got x=%h y=%h z=%h st=%0d",
                       want.fx, want.fy, want.fz, want.st, got.fx, got.fy, got.fz, got.st);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
    end
  end

endmodule

// ----- tb/double_layer_near_field_kernel_test.sv -----
// Top of the kernel testbench: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module double_layer_near_field_kernel_test;

  localparam int SETTLE_CYCLES = 200;
  localparam int STALL_LIMIT   = 20000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [383:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [95:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  int           mismatch_count;
  int           fields_pending;
  int           send_idle_pct = 29;
  int           recv_idle_pct = 67;
  int           quiet_cycles = 0;

  always #4 clk = ~clk;

  double_layer_near_field_kernel i_dut (.*);

  double_layer_near_field_kernel_checker i_checker (.*);

  // Receiver back-pressure.
  always @(negedge clk) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

  // Watchdog on cycles with no beat on either side.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (!rst) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Drive one input beat and wait until it is taken.
  task automatic send_pair(input logic [31:0] v [12]);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    for (int i = 0; i < 12; i++) s_axis_tdata[32*i +: 32] <= v[i];
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // Random Q16.16 value: full range, or near zero with a random scale.
  function automatic logic [31:0] rand_q(input bit near);
    logic [31:0] r;
    r = $urandom;
    if (near) r = $signed(r) >>> $urandom_range(31, 8);
    return r;
  endfunction

  task automatic send_random(input int kind);
    logic [31:0] v [12];
    for (int i = 0; i < 12; i++) v[i] = rand_q(kind != 0);
    // Evaluation point close to the source point: results mostly in range.
    if (kind == 1) for (int i = 0; i < 3; i++)
      v[i] = v[3+i] + (32'($signed($urandom)) >>> $urandom_range(31, 12));
    if (kind == 2) for (int i = 0; i < 3; i++) v[i] = v[3+i];
    send_pair(v);
  endtask

  initial begin
    logic [31:0] v [12];
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed beats: extremes, zero distance, zero numerators, saturation.
    for (int k = 0; k < 14; k++) begin
      for (int i = 0; i < 12; i++) v[i] = 32'h0001_0000;
      case (k)
        0: for (int i = 0; i < 12; i++) v[i] = 32'h7FFF_FFFF;
        1: for (int i = 0; i < 12; i++) v[i] = 32'h8000_0000;
        2: begin
          for (int i = 0; i < 3; i++) begin
            v[i] = 32'h7FFF_FFFF;
            v[3+i] = 32'h8000_0000;
            v[6+i] = 32'h8000_0000;
            v[9+i] = 32'h7FFF_FFFF;
          end
        end
        3: v[0] = 32'h0002_0000;
        4: begin
          v[0] = 32'h0001_0001;
          v[6] = 32'h7FFF_FFFF;
          v[7] = 32'h8000_0000;
        end
        5: begin
          v[0] = 32'h0002_0000;
          for (int i = 9; i < 12; i++) v[i] = 32'h0;
        end
        6: begin
          v[0] = 32'h0002_0000;
          for (int i = 6; i < 9; i++) v[i] = 32'h0;
        end
        7: begin
          v[0] = 32'h0002_0000;
          v[9] = 32'hFFFF_0000;
          v[7] = 32'hFFFF_8000;
        end
        8: begin
          v[1] = 32'h0001_0000 - 32'd1;
          v[10] = 32'h8000_0000;
        end
        9: for (int i = 0; i < 12; i++) v[i] = 32'h0;
        10: for (int i = 0; i < 12; i++) v[i] = 32'hFFFF_FFFF;
        11: begin
          v[2] = 32'h0;
          v[11] = 32'hFFFF_FFFF;
        end
        default: for (int i = 0; i < 12; i++) v[i] = rand_q(k[0]);
      endcase
      send_pair(v);
    end

    // Random beats in three back-pressure phases.
    for (int n = 0; n < 1700; n++) begin
      if (n == 570) begin
        send_idle_pct = 67;
        recv_idle_pct = 29;
      end else if (n == 1140) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case ($urandom_range(19))
        0: send_random(2);
        1, 2, 3, 4: send_random(0);
        5, 6, 7, 8, 9: send_random(3);
        default: send_random(1);
      endcase
    end
    s_axis_tvalid <= 1'b0;

    while (fields_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
